// ----- src/tbn_pkg.sv -----
// shared types and constants for the text byte normalizer
// no dependencies
package tbn_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [7:0] LEAD_D0    = 8'hD0;
    localparam logic [7:0] LEAD_D1    = 8'hD1;
    localparam logic [7:0] CONT_LO    = 8'h80;
    localparam logic [7:0] CONT_HI    = 8'hBF;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    localparam logic [1:0] BEAT_FIRST  = 2'd0;
    localparam logic [1:0] BEAT_SECOND = 2'd1;
    localparam logic [1:0] BEAT_THIRD  = 2'd2;

    typedef struct packed {
        logic       has_space;
        logic       has_pair;
        logic [7:0] byte0;
        logic [7:0] byte1;
    } job_t;

endpackage

// ----- src/tbn_front.sv -----
// front end: classifies each input item and tracks text state
// depends on tbn_pkg
module tbn_front
    import tbn_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_fire,
    input  logic [7:0] in_byte,
    input  logic       end_of_text,
    output logic       job_push,
    output job_t       job
);

    logic text_started_reg, text_started_next;
    logic space_pending_reg, space_pending_next;
    logic lead_held_reg, lead_held_next;
    logic lead_low_bit_reg, lead_low_bit_next;

    logic is_cont, is_lead, is_letter, is_digit, is_white;
    logic pair, keep, emit;

    always_comb begin
        is_cont   = (in_byte >= CONT_LO) && (in_byte <= CONT_HI);
        is_lead   = (in_byte == LEAD_D0) || (in_byte == LEAD_D1);
        is_letter = ((in_byte >= 8'h41) && (in_byte <= 8'h5A))
                 || ((in_byte >= 8'h61) && (in_byte <= 8'h7A));
        is_digit  = (in_byte >= 8'h30) && (in_byte <= 8'h39);
        is_white  = (in_byte == CHAR_SPACE) || (in_byte == CHAR_TAB)
                 || (in_byte == CHAR_LF) || (in_byte == CHAR_CR);
        pair      = lead_held_reg && is_cont;
        keep      = is_letter || is_digit;
        emit      = pair || keep;

        job.has_space = space_pending_reg;
        job.has_pair  = pair;
        job.byte0     = pair ? {LEAD_D0[7:1], lead_low_bit_reg} : in_byte;
        job.byte1     = in_byte;
        job_push      = in_fire && emit;

        text_started_next  = text_started_reg;
        space_pending_next = space_pending_reg;
        lead_held_next     = lead_held_reg;
        lead_low_bit_next  = lead_low_bit_reg;
        if (in_fire) begin
            if (end_of_text) begin
                text_started_next  = 1'b0;
                space_pending_next = 1'b0;
                lead_held_next     = 1'b0;
                lead_low_bit_next  = 1'b0;
            end else begin
                lead_held_next    = !pair && is_lead;
                lead_low_bit_next = (!pair && is_lead) ? in_byte[0] : lead_low_bit_reg;
                text_started_next = text_started_reg || emit;
                if (emit) begin
                    space_pending_next = 1'b0;
                end else if (is_white && text_started_reg) begin
                    space_pending_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_started_reg  <= 1'b0;
            space_pending_reg <= 1'b0;
            lead_held_reg     <= 1'b0;
            lead_low_bit_reg  <= 1'b0;
        end else begin
            text_started_reg  <= text_started_next;
            space_pending_reg <= space_pending_next;
            lead_held_reg     <= lead_held_next;
            lead_low_bit_reg  <= lead_low_bit_next;
        end
    end

endmodule

// ----- src/tbn_queue.sv -----
// small job queue between front and back ends
// depends on tbn_pkg
module tbn_queue
    import tbn_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head_job,
    output logic empty,
    output logic full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    always_comb begin
        empty    = (count_reg == '0);
        full     = (count_reg == CNT_FULL);
        do_push  = push && !full;
        do_pop   = pop && !empty;
        head_job = slots_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- src/tbn_back.sv -----
// back end: expands each queued job into one to three output items
// depends on tbn_pkg
module tbn_back
    import tbn_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  job_t       head_job,
    input  logic       empty,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       run_last
);

    logic [1:0] beat_reg, beat_next;
    logic [1:0] last_beat;
    logic       fire;

    always_comb begin
        last_beat = 2'({1'b0, head_job.has_space} + {1'b0, head_job.has_pair});
        out_valid = !empty;
        run_last  = (beat_reg == last_beat);
        fire      = out_valid && out_ready;
        pop       = fire && run_last;

        case (beat_reg)
            BEAT_FIRST:  out_byte = head_job.has_space ? CHAR_SPACE : head_job.byte0;
            BEAT_SECOND: out_byte = head_job.has_space ? head_job.byte0 : head_job.byte1;
            BEAT_THIRD:  out_byte = head_job.byte1;
            default:     out_byte = head_job.byte1;
        endcase

        beat_next = beat_reg;
        if (fire) begin
            beat_next = run_last ? BEAT_FIRST : beat_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg <= BEAT_FIRST;
        end else begin
            beat_reg <= beat_next;
        end
    end

endmodule

// ----- src/text_byte_normalizer_unit.sv -----
// top level of the text byte normalizer: front end, job queue, back end
// depends on tbn_pkg, tbn_front, tbn_queue, tbn_back
//
// input channel s_*: one raw text byte per item, s_tlast marks the last
// byte of a document; the text state is cleared after that byte.
// output channel m_*: kept bytes and single separating spaces, m_tlast set
// on the last output item caused by one input byte.
// an input byte causes zero to three output items (space, byte, or a
// two-byte d0/d1 sequence). the front end classifies one byte per cycle
// while the queue is not full and pushes a job into a QUEUE_DEPTH-entry
// queue; the back end drains one output item per cycle from the queue
// head while the receiver is ready. each job is registered in the queue
// before the back end sees it. throughput: one input byte per cycle while
// jobs average one output item; a job of n items stays at the queue head
// until all n are taken, and the input stalls once the queue is full.
// reset clears the text state and empties the queue.
// when the receiver stalls, m_* holds and the queue keeps taking input
// until it fills.
module text_byte_normalizer_unit
    import tbn_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       s_tlast,   // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tlast    // run_last
);

    logic job_push, queue_full, queue_empty, job_pop, in_fire;
    job_t push_job, head_job;

    assign s_tready = !queue_full;
    assign in_fire  = s_tvalid && s_tready;

    tbn_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .in_byte     (s_tdata),
        .end_of_text (s_tlast),
        .job_push    (job_push),
        .job         (push_job)
    );

    tbn_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_job (push_job),
        .pop      (job_pop),
        .head_job (head_job),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    tbn_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_job  (head_job),
        .empty     (queue_empty),
        .pop       (job_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .run_last  (m_tlast)
    );

endmodule

// ----- verif/tb_top.sv -----
// testbench for text_byte_normalizer_unit: directed and random text documents,
// with a self-contained predictor of kept bytes, separating spaces and d0/d1 pairs
// depends on tbn_pkg and the text_byte_normalizer_unit rtl
`timescale 1ns / 100ps

module tb_top;
    import tbn_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       eot;
        logic       drain;
    } text_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } norm_beat_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    text_item_t text_bytes [$];
    norm_beat_t expected_out [$];

    // predictor state for the current document
    logic doc_has_text = 1'b0;
    logic space_owed = 1'b0;
    logic lead_waiting = 1'b0;
    logic lead_odd = 1'b0;

    int unsigned predicted_count = 0;
    int unsigned checked_count = 0;
    int unsigned bytes_accepted = 0;
    int unsigned drains_done = 0;
    int unsigned doc_count = 0;
    int unsigned error_count = 0;
    int unsigned send_hold = 0;
    int unsigned ready_hold = 0;
    int unsigned cycle_no = 0;
    logic        calm;

    text_byte_normalizer_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1;
    end

    // the cycle count is split into equal stretches; every third stretch picks no gaps on either side
    assign calm = ((cycle_no / 300) % 3) == 2;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end else begin
            return $urandom_range(8, 30);
        end
    endfunction

    task automatic normalize_byte(input logic [7:0] b, input logic eot);
        logic [7:0] outs [$];
        logic       paired;
        norm_beat_t beat;
        paired = 1'b0;
        if (lead_waiting) begin
            lead_waiting = 1'b0;
            if (b >= CONT_LO && b <= CONT_HI) begin
                if (space_owed) begin
                    outs = {outs, CHAR_SPACE};
                end
                space_owed = 1'b0;
                doc_has_text = 1'b1;
                outs = {outs, (lead_odd ? LEAD_D1 : LEAD_D0)};
                outs = {outs, b};
                paired = 1'b1;
            end
        end
        if (!paired) begin
            if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || (b >= "0" && b <= "9")) begin
                if (space_owed) begin
                    outs = {outs, CHAR_SPACE};
                end
                space_owed = 1'b0;
                doc_has_text = 1'b1;
                outs = {outs, b};
            end else if ((b == LEAD_D0 || b == LEAD_D1) && !eot) begin
                lead_waiting = 1'b1;
                lead_odd = b[0];
            end else if (b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_LF || b == CHAR_CR) begin
                if (doc_has_text) begin
                    space_owed = 1'b1;
                end
            end
        end
        foreach (outs[i]) begin
            beat.data = outs[i];
            beat.last = (i == outs.size() - 1);
            expected_out = {expected_out, beat};
        end
        predicted_count += outs.size();
        if (eot) begin
            doc_has_text = 1'b0;
            space_owed = 1'b0;
            lead_waiting = 1'b0;
            lead_odd = 1'b0;
            doc_count++;
        end
    endtask

    always @(posedge aclk) begin : drive_proc
        text_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                normalize_byte(s_tdata, s_tlast);
                bytes_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_hold > 0) begin
                    send_hold--;
                    s_tvalid <= 1'b0;
                end else if (text_bytes.size() != 0 && text_bytes[0].drain) begin
                    // hold off until the output side has caught up
                    s_tvalid <= 1'b0;
                    if (predicted_count == checked_count) begin
                        void'(text_bytes.pop_front());
                        drains_done++;
                    end
                end else if (text_bytes.size() != 0) begin
                    nxt = text_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= nxt.data;
                    s_tlast <= nxt.eot;
                    send_hold = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : check_proc
        norm_beat_t exp_beat;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                checked_count <= checked_count + 1;
                if (expected_out.size() == 0) begin
                    $display("%0t: unexpected item out_byte %h run_last %b",
                             $time, m_tdata, m_tlast);
                    error_count++;
                end else begin
                    exp_beat = expected_out.pop_front();
                    if (m_tdata !== exp_beat.data) begin
                        $display("%0t: out_byte mismatch expected %h actual %h",
                                 $time, exp_beat.data, m_tdata);
                        error_count++;
                    end
                    if (m_tlast !== exp_beat.last) begin
                        $display("%0t: run_last mismatch expected %b actual %b",
                                 $time, exp_beat.last, m_tlast);
                        error_count++;
                    end
                end
            end
            if (ready_hold > 0) begin
                ready_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                ready_hold = pick_gap();
            end
        end
    end

    task automatic add_byte(input logic [7:0] b, input logic eot);
        text_item_t it;
        it.data = b;
        it.eot = eot;
        it.drain = 1'b0;
        text_bytes = {text_bytes, it};
    endtask

    task automatic add_drain();
        text_item_t it;
        it.data = 8'h00;
        it.eot = 1'b0;
        it.drain = 1'b1;
        text_bytes = {text_bytes, it};
    endtask

    function automatic logic [7:0] any_white();
        case ($urandom_range(0, 3))
            0: return CHAR_SPACE;
            1: return CHAR_TAB;
            2: return CHAR_LF;
            default: return CHAR_CR;
        endcase
    endfunction

    initial begin
        int unsigned len;
        int unsigned r;
        int unsigned k;
        logic [7:0]  b;
        // leading whitespace, then letters and digits at their bounds
        add_byte(CHAR_SPACE, 1'b0);
        add_byte(CHAR_TAB, 1'b0);
        add_byte("A", 1'b0);
        add_byte("z", 1'b0);
        add_byte("0", 1'b0);
        add_byte("9", 1'b0);
        // whitespace run with a dropped byte inside
        add_byte(CHAR_SPACE, 1'b0);
        add_byte(8'h21, 1'b0);
        add_byte(CHAR_CR, 1'b0);
        add_byte(CHAR_LF, 1'b0);
        add_byte("b", 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        // lead pairs, with and without a pending space
        add_byte(LEAD_D0, 1'b0);
        add_byte(CONT_LO, 1'b0);
        add_byte(CHAR_SPACE, 1'b0);
        add_byte(LEAD_D1, 1'b0);
        add_byte(CONT_HI, 1'b0);
        // lead followed by a letter, then a lead replaced by another lead
        add_byte(LEAD_D0, 1'b0);
        add_byte("c", 1'b0);
        add_byte(LEAD_D0, 1'b0);
        add_byte(LEAD_D1, 1'b0);
        add_byte(8'h90, 1'b0);
        add_byte(8'h85, 1'b0);
        // trailing space and a lead on the last byte
        add_byte(CHAR_SPACE, 1'b0);
        add_byte(LEAD_D1, 1'b1);
        add_byte(LEAD_D0, 1'b0);
        add_byte(8'hA0, 1'b1);
        add_drain();

        k = 0;
        while (k < 150) begin
            len = $urandom_range(1, 24);
            for (int j = 0; j < len; j++) begin
                r = $urandom_range(0, 99);
                if (r < 30) begin
                    r = $urandom_range(0, 51);
                    b = (r < 26) ? 8'("A" + r) : 8'("a" + r - 26);
                end else if (r < 40) begin
                    b = 8'("0" + $urandom_range(0, 9));
                end else if (r < 58) begin
                    b = any_white();
                end else if (r < 72) begin
                    add_byte($urandom_range(0, 1) ? LEAD_D1 : LEAD_D0, 1'b0);
                    k++;
                    b = 8'($urandom_range(CONT_LO, CONT_HI));
                end else if (r < 78) begin
                    add_byte($urandom_range(0, 1) ? LEAD_D1 : LEAD_D0, 1'b0);
                    k++;
                    b = 8'($urandom_range(0, 255));
                end else if (r < 84) begin
                    b = 8'($urandom_range(CONT_LO, CONT_HI));
                end else if (r < 87 && j == len - 1) begin
                    b = $urandom_range(0, 1) ? LEAD_D1 : LEAD_D0;
                end else begin
                    b = 8'($urandom_range(0, 255));
                end
                add_byte(b, j == len - 1);
                k++;
            end
            if ($urandom_range(0, 9) == 0) begin
                add_drain();
            end
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (text_bytes.size() != 0 || s_tvalid) @(negedge aclk);
        while (predicted_count != checked_count) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (expected_out.size() != 0) begin
            $display("%0t: %0d expected items never arrived", $time, expected_out.size());
            error_count++;
        end

        $display("covered %0d text bytes in %0d documents, %0d output items checked",
                 bytes_accepted, doc_count, checked_count);
        $display("sender held off for the output side %0d times, %0d errors",
                 drains_done, error_count);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
src/tbn_pkg.sv
src/tbn_front.sv
src/tbn_queue.sv
src/tbn_back.sv
src/text_byte_normalizer_unit.sv
verif/tb_top.sv
